>>> rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the pheromone field engine.
// No dependencies; every other file imports this package.
package pfe_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_DEPOSIT = 2'd0;
    localparam logic [1:0] FUNC_DECAY   = 2'd1;
    localparam logic [1:0] FUNC_SENSE   = 2'd2;
    localparam logic [1:0] FUNC_LOAD    = 2'd3;

    // Configuration register indexes
    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam int CFG_W      = 9;
    localparam int CFG_RESET  = 256;
    localparam int ANGLE_W    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W     = 5;
    localparam int TURN_BITS  = 24;
    localparam int TURN_ACC_W = 26;
    localparam int MOM_SHIFT  = 28;
    localparam int ATAN_W     = 22;
    localparam int WEIGHT_W   = 9;
    localparam int WEIGHT_ONE = 256;
    localparam int CELL_W     = 8;
    localparam int CELL_MAX   = 255;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEP_ADDR,
        ST_DEP_READ,
        ST_DEP_WRITE,
        ST_DEC_SETUP,
        ST_DEC_READ,
        ST_DEC_WRITE,
        ST_SLOT,
        ST_WIN_ADDR,
        ST_WIN_READ,
        ST_WIN_MUL,
        ST_WIN_ACC,
        ST_ANGLE_START,
        ST_ANGLE_WAIT,
        ST_DONE
    } pfe_state_t;

    typedef struct packed {
        logic capture;
        logic load_write;
        logic clear_write;
        logic dep_addr;
        logic dep_read;
        logic dep_write;
        logic dec_setup;
        logic dec_read;
        logic dec_write;
        logic slot_step;
        logic win_addr;
        logic win_read;
        logic win_mul;
        logic win_acc;
        logic angle_start;
        logic angle_take;
    } pfe_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic dec_empty;
        logic dec_last;
        logic slot_done;
        logic kind_ok;
        logic win_last;
        logic tot_zero;
        logic angle_done;
    } pfe_status_t;

    // Arctangent of 2^-i in units of 2^24 per turn
    function automatic logic [ATAN_W-1:0] atan_unit(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 22'd2097152;
            5'd1:    r = 22'd1238021;
            5'd2:    r = 22'd654136;
            5'd3:    r = 22'd332050;
            5'd4:    r = 22'd166669;
            5'd5:    r = 22'd83416;
            5'd6:    r = 22'd41719;
            5'd7:    r = 22'd20860;
            5'd8:    r = 22'd10430;
            5'd9:    r = 22'd5215;
            5'd10:   r = 22'd2608;
            5'd11:   r = 22'd1304;
            5'd12:   r = 22'd652;
            5'd13:   r = 22'd326;
            5'd14:   r = 22'd163;
            5'd15:   r = 22'd81;
            5'd16:   r = 22'd41;
            5'd17:   r = 22'd20;
            5'd18:   r = 22'd10;
            5'd19:   r = 22'd5;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/pheromone_field_engine.sv
`timescale 1ns / 1ps
// Top level of the pheromone field engine: controller plus datapath.
// Depends on pfe_pkg, pfe_ctrl and pfe_datapath.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  item in   | start & !busy      | func pos_x pos_y pheromone_type amount
//            |                    | heading_in weight_slot weight_cell weight_value
//  result    | done (one cycle)   | found centroid_angle
//  config    | wr_en              | wr_index wr_data
//
// One item at a time; every item gives one result beat. Load writes the
// weight memory at capture; deposit forms the address, reads the cell and
// writes the saturated sum; decay walks every kind's map area over the single
// grid port (read then write per cell); sense runs the slot steps, the window
// walk, then the CORDIC and result beat (no CORDIC when the weighted sum is zero).
// After reset a clearing pass writes every grid entry, one per cycle, with
// busy high.
// The receiver cannot stall: the result beat is shown for exactly one cycle.
module pheromone_field_engine #(
    parameter int GRID_WIDTH_MAX  = 256,
    parameter int GRID_HEIGHT_MAX = 256,
    parameter int PHEROMONE_KINDS = 2,
    parameter int SENSE_RADIUS    = 4,
    parameter int SENSE_SLOTS     = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic [7:0]                   pos_x,
    input  logic [7:0]                   pos_y,
    input  logic                         pheromone_type,
    input  logic [7:0]                   amount,
    input  logic [8:0]                   heading_in,
    input  logic [2:0]                   weight_slot,
    input  logic [6:0]                   weight_cell,
    input  logic [8:0]                   weight_value,
    output logic                         done,
    output logic                         found,
    output logic [pfe_pkg::ANGLE_W-1:0]  centroid_angle,
    input  logic                         wr_en,
    input  logic                         wr_index,
    input  logic [pfe_pkg::CFG_W-1:0]    wr_data
);
    import pfe_pkg::*;

    pfe_cmd_t    cmd;
    pfe_status_t st;

    pfe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pfe_datapath #(
        .GRID_WIDTH_MAX  (GRID_WIDTH_MAX),
        .GRID_HEIGHT_MAX (GRID_HEIGHT_MAX),
        .PHEROMONE_KINDS (PHEROMONE_KINDS),
        .SENSE_RADIUS    (SENSE_RADIUS),
        .SENSE_SLOTS     (SENSE_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pheromone_type (pheromone_type),
        .amount         (amount),
        .heading_in     (heading_in),
        .weight_slot    (weight_slot),
        .weight_cell    (weight_cell),
        .weight_value   (weight_value),
        .found          (found),
        .centroid_angle (centroid_angle)
    );

endmodule

>>> rtl/pfe_cordic.sv
`timescale 1ns / 1ps
// Iterative vectoring CORDIC atan2 on the window moments, one step a cycle.
// Depends on pfe_pkg.
module pfe_cordic #(
    parameter int IN_W = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [IN_W-1:0]       mx,
    input  logic signed [IN_W-1:0]       my,
    output logic                         done,
    output logic [pfe_pkg::ANGLE_W-1:0]  angle
);
    import pfe_pkg::*;

    localparam int CW = IN_W + MOM_SHIFT + 2;

    logic signed [CW-1:0]         x_reg, x_next, y_reg, y_next;
    logic signed [CW-1:0]         xs, ys, x0, y0;
    logic signed [TURN_ACC_W-1:0] acc_reg, acc_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [TURN_BITS:0]           rounded;

    // Shift right with truncation toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                      input logic [STEP_W-1:0] s);
        logic [CW-1:0] mag;
        logic [CW-1:0] sh;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        sh  = mag >> s;
        return v[CW-1] ? -$signed(sh) : $signed(sh);
    endfunction

    always_comb
    begin
        xs = shr_trunc(x_reg, step_reg);
        ys = shr_trunc(y_reg, step_reg);
        x0 = CW'(mx);
        y0 = CW'(my);
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            // Fold the left half plane over, then scale up
            step_next = '0;
            if (mx == '0 && my == '0)
            begin
                acc_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                run_next = 1'b1;
                if (mx < 0)
                begin
                    x0       = -x0;
                    y0       = -y0;
                    acc_next = TURN_ACC_W'(1 << (TURN_BITS - 1));
                end
                else
                begin
                    acc_next = '0;
                end
                x_next = x0 <<< MOM_SHIFT;
                y_next = y0 <<< MOM_SHIFT;
            end
        end
        else if (run_reg)
        begin
            // Rotate toward the x axis
            if (y_reg > 0)
            begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + TURN_ACC_W'(atan_unit(step_reg));
            end
            else
            begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - TURN_ACC_W'(atan_unit(step_reg));
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    // Wrap to one turn and round half up to 16 bits
    assign rounded = {1'b0, acc_reg[TURN_BITS-1:0]} + (TURN_BITS+1)'(128);
    assign angle   = rounded[TURN_BITS-1:TURN_BITS-ANGLE_W];
    assign done    = done_reg;

endmodule

>>> rtl/pfe_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, intensity grid and weight memories, window
// accumulators and the atan2 unit. Depends on pfe_pkg and pfe_cordic.
module pfe_datapath #(
    parameter int GRID_WIDTH_MAX  = 256,
    parameter int GRID_HEIGHT_MAX = 256,
    parameter int PHEROMONE_KINDS = 2,
    parameter int SENSE_RADIUS    = 4,
    parameter int SENSE_SLOTS     = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pfe_pkg::pfe_cmd_t            cmd,
    output pfe_pkg::pfe_status_t         st,
    input  logic                         wr_en,
    input  logic                         wr_index,
    input  logic [pfe_pkg::CFG_W-1:0]    wr_data,
    input  logic [7:0]                   pos_x,
    input  logic [7:0]                   pos_y,
    input  logic                         pheromone_type,
    input  logic [7:0]                   amount,
    input  logic [8:0]                   heading_in,
    input  logic [2:0]                   weight_slot,
    input  logic [6:0]                   weight_cell,
    input  logic [8:0]                   weight_value,
    output logic                         found,
    output logic [pfe_pkg::ANGLE_W-1:0]  centroid_angle
);
    import pfe_pkg::*;

    localparam int WIN_SIDE   = 2 * SENSE_RADIUS + 1;
    localparam int WIN_CELLS  = WIN_SIDE * WIN_SIDE;
    localparam int GRID_CELLS = GRID_WIDTH_MAX * GRID_HEIGHT_MAX;
    localparam int DEPTH      = PHEROMONE_KINDS * GRID_CELLS;
    localparam int GA_W       = $clog2(DEPTH);
    localparam int WT_DEPTH   = SENSE_SLOTS * WIN_CELLS;
    localparam int WA_W       = $clog2(WT_DEPTH);
    localparam int EW_W       = $clog2(GRID_WIDTH_MAX + 1);
    localparam int EH_W       = $clog2(GRID_HEIGHT_MAX + 1);
    localparam int AREA_W     = $clog2(GRID_CELLS + 1);
    localparam int KC_W       = (PHEROMONE_KINDS > 1) ? $clog2(PHEROMONE_KINDS) : 1;
    localparam int CI_W       = $clog2(WIN_CELLS);
    localparam int DX_W       = $clog2(SENSE_RADIUS + 1) + 1;
    localparam int CX_W       = $clog2(256 + SENSE_RADIUS) + 1;
    localparam int SLOT_STEP  = ((360 / SENSE_SLOTS) > 0) ? (360 / SENSE_SLOTS) : 1;
    localparam int TWO_STEP   = 2 * SLOT_STEP;
    localparam int REM_W      = $clog2(2 * 511 + SLOT_STEP + 1);
    localparam int SL_W       = (SENSE_SLOTS > 1) ? $clog2(SENSE_SLOTS) : 1;
    localparam int V_W        = WEIGHT_W + CELL_W;
    localparam int TOT_W      = V_W + $clog2(WIN_CELLS + 1);
    localparam int MOM_W      = V_W + DX_W + $clog2(WIN_CELLS + 1);

    // Config registers and effective map size
    logic [CFG_W-1:0]  map_width_reg, map_height_reg;
    logic [EW_W-1:0]   w_eff;
    logic [EH_W-1:0]   h_eff;

    // Captured item
    logic [7:0]        pos_x_reg, pos_y_reg, amount_reg;
    logic              kind_reg;
    logic [GA_W-1:0]   kind_base;

    // Grid memory port
    logic [CELL_W-1:0] grid_mem [DEPTH];
    logic [CELL_W-1:0] gq_reg;
    logic [GA_W-1:0]   mem_addr;
    logic              mem_we;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W:0]   dep_sum;

    // Weight memory port
    logic [WEIGHT_W-1:0] wt_mem [WT_DEPTH];
    logic [WEIGHT_W-1:0] wq_reg;
    logic [WA_W-1:0]     load_addr;
    logic                load_ok;
    logic [WEIGHT_W-1:0] load_val;

    // Sweeps and item state
    logic [GA_W-1:0]   clr_addr_reg;
    logic [GA_W-1:0]   dep_addr_reg;
    logic              dep_ok_reg;
    logic [AREA_W-1:0] area_reg, dec_cnt_reg;
    logic [KC_W-1:0]   dec_kind_reg;
    logic [GA_W-1:0]   dec_base_reg, dec_addr_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [SL_W-1:0]   slot_reg;
    logic [WA_W-1:0]   wbase_reg;

    // Window walk
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic [CI_W-1:0]         cell_reg;
    logic signed [CX_W-1:0]  cx_c, cy_c;
    logic [CX_W-2:0]         cx_u, cy_u;
    logic                    win_ok_c;
    logic [GA_W-1:0]         win_addr_reg;
    logic                    win_valid_reg;
    logic [WA_W-1:0]         waddr_reg;
    logic [V_W-1:0]          v_reg;
    logic [TOT_W-1:0]        tot_reg;
    logic signed [MOM_W-1:0] mx_reg, my_reg, v_s, dx_s, dy_s;

    // Result
    logic                found_reg;
    logic [ANGLE_W-1:0]  angle_reg;
    logic                cordic_done;
    logic [ANGLE_W-1:0]  cordic_angle;

    // Clamp the map to the grid size
    always_comb
    begin
        if (32'(map_width_reg) > 32'(GRID_WIDTH_MAX))
            w_eff = EW_W'(GRID_WIDTH_MAX);
        else
            w_eff = EW_W'(map_width_reg);
        if (32'(map_height_reg) > 32'(GRID_HEIGHT_MAX))
            h_eff = EH_W'(GRID_HEIGHT_MAX);
        else
            h_eff = EH_W'(map_height_reg);
    end

    assign kind_base = GA_W'(32'(kind_reg) * GRID_CELLS);

    // Window cell coordinates and map check
    always_comb
    begin
        cx_c = CX_W'($signed({1'b0, pos_x_reg})) + CX_W'(dx_reg);
        cy_c = CX_W'($signed({1'b0, pos_y_reg})) + CX_W'(dy_reg);
        cx_u = cx_c[CX_W-2:0];
        cy_u = cy_c[CX_W-2:0];
        win_ok_c = !cx_c[CX_W-1] && !cy_c[CX_W-1] &&
                   (32'(cx_u) < 32'(w_eff)) && (32'(cy_u) < 32'(h_eff)) &&
                   (32'(kind_reg) < PHEROMONE_KINDS);
    end

    // Weight load decode
    always_comb
    begin
        load_ok   = (32'(weight_slot) < SENSE_SLOTS) && (32'(weight_cell) < WIN_CELLS);
        load_addr = WA_W'(32'(weight_slot) * WIN_CELLS + 32'(weight_cell));
        if (32'(weight_value) > WEIGHT_ONE)
            load_val = WEIGHT_W'(WEIGHT_ONE);
        else
            load_val = weight_value;
    end

    // Select the grid port address and write data
    always_comb
    begin
        dep_sum   = {1'b0, gq_reg} + {1'b0, amount_reg};
        mem_addr  = win_addr_reg;
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (cmd.clear_write)
        begin
            mem_addr = clr_addr_reg;
            mem_we   = 1'b1;
        end
        else if (cmd.dep_read || cmd.dep_write)
        begin
            mem_addr  = dep_addr_reg;
            mem_we    = cmd.dep_write && dep_ok_reg;
            mem_wdata = dep_sum[CELL_W] ? CELL_W'(CELL_MAX) : dep_sum[CELL_W-1:0];
        end
        else if (cmd.dec_read || cmd.dec_write)
        begin
            mem_addr  = dec_addr_reg;
            mem_we    = cmd.dec_write;
            mem_wdata = (gq_reg > amount_reg) ? gq_reg - amount_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_addr] <= mem_wdata;
        gq_reg <= grid_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write && load_ok)
            wt_mem[load_addr] <= load_val;
        if (cmd.win_read)
            wq_reg <= wt_mem[waddr_reg];
    end

    // Hold the item fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_x_reg  <= pos_x;
            pos_y_reg  <= pos_y;
            kind_reg   <= pheromone_type;
            amount_reg <= amount;
        end
    end

    assign v_s  = MOM_W'($signed({1'b0, v_reg}));
    assign dx_s = MOM_W'(dx_reg);
    assign dy_s = MOM_W'(dy_reg);

    // Control registers, counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= CFG_W'(CFG_RESET);
            map_height_reg <= CFG_W'(CFG_RESET);
            clr_addr_reg   <= '0;
            dep_addr_reg   <= '0;
            dep_ok_reg     <= 1'b0;
            area_reg       <= '0;
            dec_cnt_reg    <= '0;
            dec_kind_reg   <= '0;
            dec_base_reg   <= '0;
            dec_addr_reg   <= '0;
            rem_reg        <= '0;
            slot_reg       <= '0;
            wbase_reg      <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            cell_reg       <= '0;
            win_addr_reg   <= '0;
            win_valid_reg  <= 1'b0;
            waddr_reg      <= '0;
            v_reg          <= '0;
            tot_reg        <= '0;
            mx_reg         <= '0;
            my_reg         <= '0;
            found_reg      <= 1'b0;
            angle_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_MAP_WIDTH:  map_width_reg  <= wr_data;
                    REG_MAP_HEIGHT: map_height_reg <= wr_data;
                    default:        map_width_reg  <= map_width_reg;
                endcase
            end
            if (cmd.clear_write)
                clr_addr_reg <= clr_addr_reg + GA_W'(1);
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
                angle_reg <= '0;
                rem_reg   <= REM_W'(2 * 32'(heading_in) + SLOT_STEP);
                slot_reg  <= '0;
                wbase_reg <= '0;
                dx_reg    <= DX_W'(-SENSE_RADIUS);
                dy_reg    <= DX_W'(-SENSE_RADIUS);
                cell_reg  <= '0;
                tot_reg   <= '0;
                mx_reg    <= '0;
                my_reg    <= '0;
            end
            // Deposit address
            if (cmd.dep_addr)
            begin
                dep_addr_reg <= kind_base + GA_W'(32'(pos_y_reg) * 32'(w_eff)) +
                                GA_W'(pos_x_reg);
                dep_ok_reg   <= (32'(kind_reg) < PHEROMONE_KINDS) &&
                                (32'(pos_x_reg) < 32'(w_eff)) &&
                                (32'(pos_y_reg) < 32'(h_eff));
            end
            // Decay sweep
            if (cmd.dec_setup)
            begin
                area_reg     <= AREA_W'(32'(w_eff) * 32'(h_eff));
                dec_cnt_reg  <= '0;
                dec_kind_reg <= '0;
                dec_base_reg <= '0;
                dec_addr_reg <= '0;
            end
            if (cmd.dec_write)
            begin
                if (dec_cnt_reg == area_reg - AREA_W'(1))
                begin
                    dec_cnt_reg  <= '0;
                    dec_kind_reg <= dec_kind_reg + KC_W'(1);
                    dec_base_reg <= dec_base_reg + GA_W'(GRID_CELLS);
                    dec_addr_reg <= dec_base_reg + GA_W'(GRID_CELLS);
                end
                else
                begin
                    dec_cnt_reg  <= dec_cnt_reg + AREA_W'(1);
                    dec_addr_reg <= dec_addr_reg + GA_W'(1);
                end
            end
            // Heading to slot by repeated subtraction
            if (cmd.slot_step && rem_reg >= REM_W'(TWO_STEP))
            begin
                rem_reg <= rem_reg - REM_W'(TWO_STEP);
                if (slot_reg == SL_W'(SENSE_SLOTS - 1))
                begin
                    slot_reg  <= '0;
                    wbase_reg <= '0;
                end
                else
                begin
                    slot_reg  <= slot_reg + SL_W'(1);
                    wbase_reg <= wbase_reg + WA_W'(WIN_CELLS);
                end
            end
            // Window cell addresses
            if (cmd.win_addr)
            begin
                win_addr_reg  <= kind_base + GA_W'(32'(cy_u) * 32'(w_eff)) + GA_W'(cx_u);
                win_valid_reg <= win_ok_c;
                waddr_reg     <= wbase_reg + WA_W'(cell_reg);
            end
            if (cmd.win_mul)
                v_reg <= win_valid_reg ? V_W'(wq_reg) * V_W'(gq_reg) : '0;
            // Accumulate and advance the window
            if (cmd.win_acc)
            begin
                tot_reg  <= tot_reg + TOT_W'(v_reg);
                mx_reg   <= mx_reg + v_s * dx_s;
                my_reg   <= my_reg + v_s * dy_s;
                cell_reg <= cell_reg + CI_W'(1);
                if (dx_reg == DX_W'(SENSE_RADIUS))
                begin
                    dx_reg <= DX_W'(-SENSE_RADIUS);
                    dy_reg <= dy_reg + DX_W'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + DX_W'(1);
                end
            end
            if (cmd.angle_take)
            begin
                found_reg <= 1'b1;
                angle_reg <= cordic_angle;
            end
        end
    end

    pfe_cordic #(
        .IN_W (MOM_W)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.angle_start),
        .mx    (mx_reg),
        .my    (my_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    // Status back to the controller
    always_comb
    begin
        st.clear_last = (clr_addr_reg == GA_W'(DEPTH - 1));
        st.dec_empty  = (area_reg == '0);
        st.dec_last   = (dec_cnt_reg == area_reg - AREA_W'(1)) &&
                        (dec_kind_reg == KC_W'(PHEROMONE_KINDS - 1));
        st.slot_done  = (rem_reg < REM_W'(TWO_STEP));
        st.kind_ok    = (32'(kind_reg) < PHEROMONE_KINDS);
        st.win_last   = (cell_reg == CI_W'(WIN_CELLS - 1));
        st.tot_zero   = (tot_reg == '0);
        st.angle_done = cordic_done;
    end

    assign found          = found_reg;
    assign centroid_angle = angle_reg;

endmodule

>>> rtl/pfe_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clear, deposit, decay, sense and load.
// Depends on pfe_pkg.
module pfe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            func,
    input  pfe_pkg::pfe_status_t  st,
    output pfe_pkg::pfe_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import pfe_pkg::*;

    pfe_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (st.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (func)
                        FUNC_DEPOSIT: state_next = ST_DEP_ADDR;
                        FUNC_DECAY:   state_next = ST_DEC_SETUP;
                        FUNC_SENSE:   state_next = ST_SLOT;
                        FUNC_LOAD:
                        begin
                            cmd.load_write = 1'b1;
                            state_next     = ST_DONE;
                        end
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_DEP_ADDR:
            begin
                cmd.dep_addr = 1'b1;
                state_next   = ST_DEP_READ;
            end
            ST_DEP_READ:
            begin
                cmd.dep_read = 1'b1;
                state_next   = ST_DEP_WRITE;
            end
            ST_DEP_WRITE:
            begin
                cmd.dep_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DEC_SETUP:
            begin
                cmd.dec_setup = 1'b1;
                state_next    = ST_DEC_READ;
            end
            ST_DEC_READ:
            begin
                cmd.dec_read = 1'b1;
                if (st.dec_empty)
                    state_next = ST_DONE;
                else
                    state_next = ST_DEC_WRITE;
            end
            ST_DEC_WRITE:
            begin
                cmd.dec_write = 1'b1;
                if (st.dec_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_DEC_READ;
            end
            ST_SLOT:
            begin
                cmd.slot_step = 1'b1;
                if (st.slot_done)
                    state_next = st.kind_ok ? ST_WIN_ADDR : ST_DONE;
            end
            ST_WIN_ADDR:
            begin
                cmd.win_addr = 1'b1;
                state_next   = ST_WIN_READ;
            end
            ST_WIN_READ:
            begin
                cmd.win_read = 1'b1;
                state_next   = ST_WIN_MUL;
            end
            ST_WIN_MUL:
            begin
                cmd.win_mul = 1'b1;
                state_next  = ST_WIN_ACC;
            end
            ST_WIN_ACC:
            begin
                cmd.win_acc = 1'b1;
                state_next  = st.win_last ? ST_ANGLE_START : ST_WIN_ADDR;
            end
            ST_ANGLE_START:
            begin
                if (st.tot_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.angle_start = 1'b1;
                    state_next      = ST_ANGLE_WAIT;
                end
            end
            ST_ANGLE_WAIT:
            begin
                if (st.angle_done)
                begin
                    cmd.angle_take = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
